/* hdl/sbag_pkg.sv */
// Shared types, widths and codes for the spanning block address generator.
// Used by every module of the block; depends on nothing.
package sbag_pkg;

	// Field widths of the input and result beats.
	localparam int KIND_W = 2;
	localparam int UNIT_W = 32;
	localparam int CH_W = 7;
	localparam int LUN_W = 8;
	localparam int BLK_W = 16;
	localparam int PL_W = 2;
	localparam int PG_W = 16;
	localparam int SEC_W = 4;
	localparam int MODE_W = 2;
	localparam int BUF_W = 38;

	// Configuration register widths.
	localparam int CCNT_W = 8;
	localparam int LCNT_W = 9;
	localparam int NPL_W = 3;
	localparam int PGCNT_W = 17;
	localparam int NSEC_W = 5;
	localparam int RUN_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHANNEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_LUN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LUN_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_NUMBER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = 3'd7;

	// Operation codes.
	localparam logic [KIND_W-1:0] OP_ERASE = 2'd0;
	localparam logic [KIND_W-1:0] OP_WRITE = 2'd1;
	localparam logic [KIND_W-1:0] OP_READ = 2'd2;
	localparam logic [KIND_W-1:0] OP_UNUSED = 2'd3;

	// Plane mode codes.
	localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DUAL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUAD = 2'd2;

	// Register values after reset.
	localparam logic [CH_W-1:0] RST_FIRST_CHANNEL = 7'd0;
	localparam logic [CCNT_W-1:0] RST_CHANNEL_COUNT = 8'd1;
	localparam logic [LUN_W-1:0] RST_FIRST_LUN = 8'd0;
	localparam logic [LCNT_W-1:0] RST_LUN_COUNT = 9'd1;
	localparam logic [BLK_W-1:0] RST_BLOCK_NUMBER = 16'd0;
	localparam logic [NPL_W-1:0] RST_PLANE_COUNT = 3'd1;
	localparam logic [PGCNT_W-1:0] RST_PAGE_COUNT = 17'd256;
	localparam logic [NSEC_W-1:0] RST_SECTOR_COUNT = 5'd4;

	// Iterative divider: quotient bits resolved per cycle and cycle count.
	localparam int DIV_DEND_W = 32;
	localparam int DIV_DSOR_W = 17;
	localparam int DIV_BITS_PER_STEP = 8;
	localparam int DIV_STEPS = DIV_DEND_W / DIV_BITS_PER_STEP;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic [CH_W-1:0]    first_channel;
		logic [CCNT_W-1:0]  channel_count;
		logic [LUN_W-1:0]   first_lun;
		logic [LCNT_W-1:0]  lun_count;
		logic [BLK_W-1:0]   block_number;
		logic [NPL_W-1:0]   plane_count;
		logic [PGCNT_W-1:0] page_count;
		logic [NSEC_W-1:0]  sector_count;
	} cfg_t;

	// One classified item, ready to be expanded into addresses.
	typedef struct packed {
		logic [KIND_W-1:0] op;
		logic              err;
		logic              count_buf;
		logic [CH_W-1:0]   ch;
		logic [LUN_W-1:0]  lun;
		logic [BLK_W-1:0]  blk;
		logic [MODE_W-1:0] mode;
		logic [PG_W-1:0]   page;
		logic [BUF_W-1:0]  base;
		logic [NPL_W-1:0]  nplanes;
		logic [NSEC_W-1:0] nsectors;
	} job_t;

	typedef struct packed {
		logic                  start;
		logic [DIV_DEND_W-1:0] dividend;
		logic [DIV_DSOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIV_DEND_W-1:0] quotient;
		logic [DIV_DSOR_W-1:0] remainder;
	} div_rsp_t;

endpackage

/* hdl/sbag_div.sv */
// Multi-cycle unsigned divider, several restoring steps per cycle.
// Depends on sbag_pkg for widths and the request and response structs.
module sbag_div
	import sbag_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIV_DEND_W-1:0] quo_q;
	logic [DIV_DSOR_W-1:0] rem_q;
	logic [DIV_DSOR_W-1:0] dsor_q;
	logic [DIV_DEND_W-1:0] quo_nxt;
	logic [DIV_DSOR_W-1:0] rem_nxt;

	// The dividend shifts out of the top of quo_q while quotient bits enter at the bottom.
	always_comb begin
		logic [DIV_DSOR_W:0]   r;
		logic [DIV_DEND_W-1:0] qv;
		r = {1'b0, rem_q};
		qv = quo_q;
		for (int k = 0; k < DIV_BITS_PER_STEP; k++) begin
			r = {r[DIV_DSOR_W-1:0], qv[DIV_DEND_W-1]};
			qv = {qv[DIV_DEND_W-2:0], 1'b0};
			if (r >= {1'b0, dsor_q}) begin
				r = r - {1'b0, dsor_q};
				qv[0] = 1'b1;
			end
		end
		rem_nxt = r[DIV_DSOR_W-1:0];
		quo_nxt = qv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q;

endmodule

/* hdl/sbag_front.sv */
// Front end: takes input beats, checks the span and geometry, and splits the
// unit index with the shared divider. Depends on sbag_pkg and sbag_div.
module sbag_front
	import sbag_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] kind,
	input  logic [UNIT_W-1:0] unit_index,
	input  cfg_t              cfg,
	output job_t              push_job,
	output logic              push_valid,
	input  logic              push_ready
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIVE = 6'b000010,
		S_DIVA = 6'b000100,
		S_DIVB = 6'b001000,
		S_DIVC = 6'b010000,
		S_PUSH = 6'b100000
	} front_state_t;

	front_state_t state_q;
	front_state_t state_nxt;

	logic              hold_valid_q;
	logic [KIND_W-1:0] hold_kind_q;
	logic [UNIT_W-1:0] hold_unit_q;

	logic [KIND_W-1:0] op_q;
	logic              err_q;
	logic [CH_W-1:0]   ch_q;
	logic [LUN_W-1:0]  lun_q;
	logic [PG_W-1:0]   page_q;
	logic [BUF_W-1:0]  base_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                        take;
	logic                        span_bad;
	logic                        geo_bad;
	logic                        erase_oob;
	logic                        bad;
	logic [CCNT_W+LCNT_W-1:0]    pair_total;
	logic [CCNT_W+NSEC_W-1:0]    run_len;
	logic [UNIT_W+RUN_W-1:0]     base_prod;
	logic [MODE_W-1:0]           mode;

	sbag_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready = !hold_valid_q;
	assign take = (state_q == S_IDLE) && hold_valid_q;

	// Span and geometry checks; a failure turns any item into one error beat.
	assign span_bad = (cfg.channel_count == '0) || (cfg.lun_count == '0) ||
		(({2'b0, cfg.first_channel} + {1'b0, cfg.channel_count}) > 9'd128) ||
		(({2'b0, cfg.first_lun} + {1'b0, cfg.lun_count}) > 10'd256);
	assign geo_bad = (cfg.plane_count == '0) || (cfg.plane_count > 3'd4) ||
		(cfg.sector_count == '0) || (cfg.sector_count > 5'd16) ||
		(cfg.page_count == '0) || (cfg.page_count > 17'd65536);

	assign pair_total = {{LCNT_W{1'b0}}, cfg.channel_count} *
		{{CCNT_W{1'b0}}, cfg.lun_count};
	assign erase_oob = hold_unit_q >= {{(UNIT_W-CCNT_W-LCNT_W){1'b0}}, pair_total};
	assign bad = (hold_kind_q == OP_UNUSED) || span_bad || geo_bad ||
		((hold_kind_q == OP_ERASE) && erase_oob);

	// Run length is at most 64 once the geometry check passes.
	assign run_len = {{(CCNT_W+NSEC_W-NPL_W){1'b0}}, cfg.plane_count} *
		{{CCNT_W{1'b0}}, cfg.sector_count};
	assign base_prod = {{RUN_W{1'b0}}, hold_unit_q} *
		{{UNIT_W{1'b0}}, run_len[RUN_W-1:0]};

	assign mode = (cfg.plane_count == 3'd4) ? MODE_QUAD :
		((cfg.plane_count == 3'd2) ? MODE_DUAL : MODE_SINGLE);

	always_comb begin
		state_nxt = state_q;
		div_req.start = 1'b0;
		div_req.dividend = hold_unit_q;
		div_req.divisor = {{(DIV_DSOR_W-LCNT_W){1'b0}}, cfg.lun_count};
		case (state_q)
			S_IDLE: begin
				if (take) begin
					if (bad) begin
						state_nxt = S_PUSH;
					end else if (hold_kind_q == OP_ERASE) begin
						div_req.start = 1'b1;
						state_nxt = S_DIVE;
					end else begin
						div_req.start = 1'b1;
						div_req.divisor = {{(DIV_DSOR_W-CCNT_W){1'b0}}, cfg.channel_count};
						state_nxt = S_DIVA;
					end
				end
			end
			S_DIVE: begin
				if (div_rsp.done) begin
					state_nxt = S_PUSH;
				end
			end
			S_DIVA: begin
				div_req.dividend = div_rsp.quotient;
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					state_nxt = S_DIVB;
				end
			end
			S_DIVB: begin
				div_req.dividend = div_rsp.quotient;
				div_req.divisor = cfg.page_count;
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					state_nxt = S_DIVC;
				end
			end
			S_DIVC: begin
				if (div_rsp.done) begin
					state_nxt = S_PUSH;
				end
			end
			S_PUSH: begin
				if (push_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hold_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_valid && in_ready) begin
				hold_valid_q <= 1'b1;
			end else if (take) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hold_kind_q <= kind;
			hold_unit_q <= unit_index;
		end
		if (take) begin
			op_q <= hold_kind_q;
			err_q <= bad;
			page_q <= '0;
			base_q <= (hold_kind_q == OP_ERASE) ? '0 : base_prod[BUF_W-1:0];
		end
		if (div_rsp.done) begin
			case (state_q)
				S_DIVE: begin
					ch_q <= cfg.first_channel + div_rsp.quotient[CH_W-1:0];
					lun_q <= cfg.first_lun + div_rsp.remainder[LUN_W-1:0];
				end
				S_DIVA: begin
					ch_q <= cfg.first_channel + div_rsp.remainder[CH_W-1:0];
				end
				S_DIVB: begin
					lun_q <= cfg.first_lun + div_rsp.remainder[LUN_W-1:0];
				end
				S_DIVC: begin
					page_q <= div_rsp.remainder[PG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// An error job expands to a single beat with only the operation, last and error flag set.
	always_comb begin
		push_valid = (state_q == S_PUSH);
		push_job.op = op_q;
		push_job.err = err_q;
		if (err_q) begin
			push_job.count_buf = 1'b0;
			push_job.ch = '0;
			push_job.lun = '0;
			push_job.blk = '0;
			push_job.mode = MODE_SINGLE;
			push_job.page = '0;
			push_job.base = '0;
			push_job.nplanes = NPL_W'(1);
			push_job.nsectors = NSEC_W'(1);
		end else begin
			push_job.count_buf = (op_q != OP_ERASE);
			push_job.ch = ch_q;
			push_job.lun = lun_q;
			push_job.blk = cfg.block_number;
			push_job.mode = mode;
			push_job.page = page_q;
			push_job.base = base_q;
			push_job.nplanes = cfg.plane_count;
			push_job.nsectors = (op_q == OP_ERASE) ? NSEC_W'(1) : cfg.sector_count;
		end
	end

endmodule

/* hdl/sbag_queue.sv */
// Short register queue of classified jobs between front and back.
// Depends on sbag_pkg for the job struct.
module sbag_queue
	import sbag_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_data,
	input  logic wr_valid,
	output logic wr_ready,
	output job_t rd_data,
	output logic rd_valid,
	input  logic rd_ready
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = (cnt_q != CNT_W'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = slot_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* hdl/sbag_back.sv */
// Back end: expands one job into its run of addresses, one beat per cycle
// unless the receiver stalls, via an output register. Uses sbag_pkg's job struct.
module sbag_back
	import sbag_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  job_t              job,
	input  logic              job_valid,
	output logic              job_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] operation,
	output logic [CH_W-1:0]   channel,
	output logic [LUN_W-1:0]  lun,
	output logic [BLK_W-1:0]  block,
	output logic [PL_W-1:0]   plane,
	output logic [PG_W-1:0]   page,
	output logic [SEC_W-1:0]  sector,
	output logic [MODE_W-1:0] plane_mode,
	output logic [BUF_W-1:0]  buffer_sector,
	output logic              last,
	output logic              error
);

	job_t              cur_q;
	logic              active_q;
	logic [PL_W-1:0]   plane_q;
	logic [SEC_W-1:0]  sector_q;
	logic [BUF_W-1:0]  buf_q;
	logic              out_valid_q;

	logic [NPL_W-1:0]  plane_lim;
	logic [NSEC_W-1:0] sector_lim;
	logic              sector_end;
	logic              cur_last;
	logic              out_load;
	logic              next_job;

	assign plane_lim = cur_q.nplanes - NPL_W'(1);
	assign sector_lim = cur_q.nsectors - NSEC_W'(1);
	assign sector_end = (sector_q == sector_lim[SEC_W-1:0]);
	assign cur_last = sector_end && (plane_q == plane_lim[PL_W-1:0]);

	assign out_load = active_q && (!out_valid_q || out_ready);
	assign next_job = !active_q || (out_load && cur_last);
	assign job_ready = next_job;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (next_job) begin
				active_q <= job_valid;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (next_job && job_valid) begin
			cur_q <= job;
			plane_q <= '0;
			sector_q <= '0;
			buf_q <= job.base;
		end else if (out_load) begin
			if (sector_end) begin
				sector_q <= '0;
				plane_q <= plane_q + 1'b1;
			end else begin
				sector_q <= sector_q + 1'b1;
			end
			if (cur_q.count_buf) begin
				buf_q <= buf_q + 1'b1;
			end
		end
		if (out_load) begin
			operation <= cur_q.op;
			channel <= cur_q.ch;
			lun <= cur_q.lun;
			block <= cur_q.blk;
			plane <= plane_q;
			page <= cur_q.page;
			sector <= sector_q;
			plane_mode <= cur_q.mode;
			buffer_sector <= buf_q;
			last <= cur_last;
			error <= cur_q.err;
		end
	end

endmodule

/* hdl/spanning_block_address_generator.sv */
// Spanning block address generator: turns erase, write and read items into
// a run of physical flash addresses over a span of channels and dies.
//
// Input channel (in_valid/in_ready, kind, unit_index) takes one item per beat.
// Output channel (out_valid/out_ready and the address fields) gives one
// address per beat; last marks the final beat of an item's run and error
// marks the single beat that stands for a rejected item.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register
// per cycle and is to be used only while the block holds no item.
//
// The front end splits the unit index with one shared divider that
// resolves eight quotient bits per cycle: one division for an erase, three
// for a read or write and none for a rejected item. The back end then
// emits planes times sectors beats for a read or write, planes beats for
// an erase and one for a rejected item, one per cycle while the receiver
// is ready. A job queue lets the front work on the next item while the
// back emits. Reset clears all control state and loads the register
// defaults. When the receiver stalls, the output register holds its beat,
// the queue fills and in_ready falls once the front has nowhere to put
// its next job.
module spanning_block_address_generator
	import sbag_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [KIND_W-1:0]     kind,
	input  logic [UNIT_W-1:0]     unit_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KIND_W-1:0]     operation,
	output logic [CH_W-1:0]       channel,
	output logic [LUN_W-1:0]      lun,
	output logic [BLK_W-1:0]      block,
	output logic [PL_W-1:0]       plane,
	output logic [PG_W-1:0]       page,
	output logic [SEC_W-1:0]      sector,
	output logic [MODE_W-1:0]     plane_mode,
	output logic [BUF_W-1:0]      buffer_sector,
	output logic                  last,
	output logic                  error
);

	cfg_t cfg_q;
	job_t push_job;
	logic push_valid;
	logic push_ready;
	job_t pop_job;
	logic pop_valid;
	logic pop_ready;

	// Configuration registers; each write keeps only the register's own width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_channel <= RST_FIRST_CHANNEL;
			cfg_q.channel_count <= RST_CHANNEL_COUNT;
			cfg_q.first_lun <= RST_FIRST_LUN;
			cfg_q.lun_count <= RST_LUN_COUNT;
			cfg_q.block_number <= RST_BLOCK_NUMBER;
			cfg_q.plane_count <= RST_PLANE_COUNT;
			cfg_q.page_count <= RST_PAGE_COUNT;
			cfg_q.sector_count <= RST_SECTOR_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRST_CHANNEL: cfg_q.first_channel <= cfg_data[CH_W-1:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[CCNT_W-1:0];
				REG_FIRST_LUN:     cfg_q.first_lun <= cfg_data[LUN_W-1:0];
				REG_LUN_COUNT:     cfg_q.lun_count <= cfg_data[LCNT_W-1:0];
				REG_BLOCK_NUMBER:  cfg_q.block_number <= cfg_data[BLK_W-1:0];
				REG_PLANE_COUNT:   cfg_q.plane_count <= cfg_data[NPL_W-1:0];
				REG_PAGE_COUNT:    cfg_q.page_count <= cfg_data[PGCNT_W-1:0];
				REG_SECTOR_COUNT:  cfg_q.sector_count <= cfg_data[NSEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sbag_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.unit_index (unit_index),
		.cfg        (cfg_q),
		.push_job   (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	sbag_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (push_job),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.rd_data  (pop_job),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready)
	);

	sbag_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (pop_job),
		.job_valid     (pop_valid),
		.job_ready     (pop_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.operation     (operation),
		.channel       (channel),
		.lun           (lun),
		.block         (block),
		.plane         (plane),
		.page          (page),
		.sector        (sector),
		.plane_mode    (plane_mode),
		.buffer_sector (buffer_sector),
		.last          (last),
		.error         (error)
	);

endmodule

/* bench/tb_spanning_block_address_generator.sv */
// Self-checking bench for the spanning block address generator.
// Depends on sbag_pkg and the spanning_block_address_generator module only.
module tb_spanning_block_address_generator;
	import sbag_pkg::*;

	// One address beat as it leaves the block.
	typedef struct packed {
		logic [KIND_W-1:0] op;
		logic [CH_W-1:0]   ch;
		logic [LUN_W-1:0]  lun;
		logic [BLK_W-1:0]  blk;
		logic [PL_W-1:0]   pl;
		logic [PG_W-1:0]   pg;
		logic [SEC_W-1:0]  sec;
		logic [MODE_W-1:0] mode;
		logic [BUF_W-1:0]  bufs;
		logic              last;
		logic              err;
	} flash_addr_t;

	// One request beat waiting to be offered to the block.
	typedef struct packed {
		logic [KIND_W-1:0] k;
		logic [UNIT_W-1:0] u;
	} flash_req_t;

	// Cycles without any accepted beat on either channel before the run is declared hung.
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_REQS = 480;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [KIND_W-1:0]     kind = '0;
	logic [UNIT_W-1:0]     unit_index = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [KIND_W-1:0]     operation;
	logic [CH_W-1:0]       channel;
	logic [LUN_W-1:0]      lun;
	logic [BLK_W-1:0]      block;
	logic [PL_W-1:0]       plane;
	logic [PG_W-1:0]       page;
	logic [SEC_W-1:0]      sector;
	logic [MODE_W-1:0]     plane_mode;
	logic [BUF_W-1:0]      buffer_sector;
	logic                  last;
	logic                  error;

	spanning_block_address_generator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.unit_index(unit_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.operation(operation),
		.channel(channel),
		.lun(lun),
		.block(block),
		.plane(plane),
		.page(page),
		.sector(sector),
		.plane_mode(plane_mode),
		.buffer_sector(buffer_sector),
		.last(last),
		.error(error)
	);

	always #4 clk = ~clk;

	// Our copy of the span registers, mirrored on every write we issue.
	cfg_t span;

	flash_req_t  pending_reqs[$];
	flash_addr_t expected_addrs[$];
	int          reqs_queued = 0;
	int          reqs_accepted = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;
	logic        in_beat_taken = 1'b0;

	// Idling style for the current phase: tx_mode 0 offers back to back,
	// otherwise bursts with gaps. rx_mode 0 never stalls, 1 stalls at
	// random, 2 alternates runs of ready and runs of stall.
	int tx_mode = 0;
	int rx_mode = 0;
	int tx_burst = 0;
	int tx_gap = 0;
	int rx_run = 0;
	logic rx_stalling = 1'b0;

	// Expands one accepted request into the address beats it should produce.
	// Any rejected request (unused kind, span outside the channel or die
	// range, zero counts, bad geometry, or an erase pair beyond the span)
	// collapses to one beat with only the operation, last and error set.
	function automatic void expand_request(logic [KIND_W-1:0] k, logic [UNIT_W-1:0] u);
		longint unsigned fc, cc, fl, lc, np, npg, ns, ui, q, run_len, base, i;
		flash_addr_t a;
		bit rejected;
		fc = span.first_channel;
		cc = span.channel_count;
		fl = span.first_lun;
		lc = span.lun_count;
		np = span.plane_count;
		npg = span.page_count;
		ns = span.sector_count;
		ui = u;
		rejected = (k == OP_UNUSED) || cc == 0 || lc == 0 || fc + cc > 128 ||
			fl + lc > 256 || np == 0 || np > 4 || ns == 0 || ns > 16 ||
			npg == 0 || npg > 65536;
		if (!rejected && k == OP_ERASE && ui >= cc * lc)
			rejected = 1'b1;
		a = '0;
		a.op = k;
		if (rejected) begin
			a.last = 1'b1;
			a.err = 1'b1;
			expected_addrs.push_back(a);
			return;
		end
		a.blk = span.block_number;
		// Three planes fall back to single plane mode.
		a.mode = (np == 4) ? MODE_QUAD : ((np == 2) ? MODE_DUAL : MODE_SINGLE);
		if (k == OP_ERASE) begin
			// Channel is the outer loop of the pair index.
			a.ch = CH_W'(fc + ui / lc);
			a.lun = LUN_W'(fl + ui % lc);
			for (i = 0; i < np; i++) begin
				a.pl = PL_W'(i);
				a.last = (i + 1 == np);
				expected_addrs.push_back(a);
			end
		end else begin
			// A stripe unit walks channels first, then dies, then pages.
			a.ch = CH_W'(fc + ui % cc);
			q = ui / cc;
			a.lun = LUN_W'(fl + q % lc);
			a.pg = PG_W'((q / lc) % npg);
			run_len = np * ns;
			base = ui * run_len;
			for (i = 0; i < run_len; i++) begin
				a.pl = PL_W'(i / ns);
				a.sec = SEC_W'(i % ns);
				a.bufs = BUF_W'(base + i);
				a.last = (i + 1 == run_len);
				expected_addrs.push_back(a);
			end
		end
	endfunction

	function automatic string addr_text(flash_addr_t a);
		return $sformatf("op=%0d ch=%0d lun=%0d blk=%0d pl=%0d pg=%0d sec=%0d mode=%0d buf=%0d last=%0b err=%0b",
			a.op, a.ch, a.lun, a.blk, a.pl, a.pg, a.sec, a.mode, a.bufs, a.last, a.err);
	endfunction

	// Request driver. A new beat is offered only once the previous one was
	// taken (or nothing was offered), so valid and payload hold while waiting.
	always @(negedge clk) begin : req_driver
		flash_req_t req;
		if (arst_n && (!in_valid || in_beat_taken)) begin
			if (tx_gap > 0) begin
				in_valid <= 1'b0;
				tx_gap = tx_gap - 1;
			end else if (pending_reqs.size() != 0) begin
				req = pending_reqs.pop_front();
				in_valid <= 1'b1;
				kind <= req.k;
				unit_index <= req.u;
				tx_burst = tx_burst - 1;
				if (tx_burst <= 0) begin
					tx_burst = $urandom_range(1, 8);
					tx_gap = (tx_mode != 0) ? $urandom_range(1, 10) : 0;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver backpressure.
	always @(negedge clk) begin
		case (rx_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (rx_run <= 0) begin
					rx_stalling = !rx_stalling;
					rx_run = rx_stalling ? $urandom_range(1, 20) : $urandom_range(1, 10);
				end
				rx_run = rx_run - 1;
				out_ready <= !rx_stalling;
			end
		endcase
	end

	// Monitor: checks each address beat against the oldest expectation, then
	// predicts the beats of any request accepted at this edge. A request
	// never produces a beat at the edge where it is accepted.
	always @(posedge clk) begin : addr_monitor
		flash_addr_t got, want;
		in_beat_taken <= in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			got.op = operation;
			got.ch = channel;
			got.lun = lun;
			got.blk = block;
			got.pl = plane;
			got.pg = page;
			got.sec = sector;
			got.mode = plane_mode;
			got.bufs = buffer_sector;
			got.last = last;
			got.err = error;
			if (expected_addrs.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected address beat: %s", addr_text(got));
				mismatches = mismatches + 1;
			end else begin
				want = expected_addrs.pop_front();
				if (got !== want) begin
					if (mismatches < 10) begin
						$display("address mismatch at %0t", $realtime);
						$display("  expected %s", addr_text(want));
						$display("  actual   %s", addr_text(got));
					end
					mismatches = mismatches + 1;
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			expand_request(kind, unit_index);
			reqs_accepted = reqs_accepted + 1;
		end
	end

	// Watchdog on forward progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_spanning_block_address_generator NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Register writes go out one per cycle; the mirror follows the same
	// masking the port applies.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FIRST_CHANNEL: span.first_channel = val[CH_W-1:0];
			REG_CHANNEL_COUNT: span.channel_count = val[CCNT_W-1:0];
			REG_FIRST_LUN:     span.first_lun = val[LUN_W-1:0];
			REG_LUN_COUNT:     span.lun_count = val[LCNT_W-1:0];
			REG_BLOCK_NUMBER:  span.block_number = val[BLK_W-1:0];
			REG_PLANE_COUNT:   span.plane_count = val[NPL_W-1:0];
			REG_PAGE_COUNT:    span.page_count = val[PGCNT_W-1:0];
			REG_SECTOR_COUNT:  span.sector_count = val[NSEC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_span(cfg_t c);
		write_reg(REG_FIRST_CHANNEL, CFG_DATA_W'(c.first_channel));
		write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(c.channel_count));
		write_reg(REG_FIRST_LUN, CFG_DATA_W'(c.first_lun));
		write_reg(REG_LUN_COUNT, CFG_DATA_W'(c.lun_count));
		write_reg(REG_BLOCK_NUMBER, CFG_DATA_W'(c.block_number));
		write_reg(REG_PLANE_COUNT, CFG_DATA_W'(c.plane_count));
		write_reg(REG_PAGE_COUNT, CFG_DATA_W'(c.page_count));
		write_reg(REG_SECTOR_COUNT, CFG_DATA_W'(c.sector_count));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic cfg_t span_of(int fc, int cc, int fl, int lc, int blk, int np,
		int npg, int ns);
		cfg_t c;
		c.first_channel = CH_W'(fc);
		c.channel_count = CCNT_W'(cc);
		c.first_lun = LUN_W'(fl);
		c.lun_count = LCNT_W'(lc);
		c.block_number = BLK_W'(blk);
		c.plane_count = NPL_W'(np);
		c.page_count = PGCNT_W'(npg);
		c.sector_count = NSEC_W'(ns);
		return c;
	endfunction

	// Mostly legal spans with short runs; now and then one register is
	// pushed outside its legal range so that every request is rejected.
	function automatic cfg_t random_span();
		int fc, cc, fl, lc, np, npg, ns;
		fc = $urandom_range(0, 127);
		cc = $urandom_range(1, 128 - fc);
		fl = $urandom_range(0, 255);
		lc = $urandom_range(1, 256 - fl);
		np = $urandom_range(1, 4);
		ns = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
		case ($urandom_range(0, 3))
			0: npg = 1;
			1: npg = 65536;
			2: npg = $urandom_range(1, 8);
			default: npg = $urandom_range(1, 65536);
		endcase
		case ($urandom_range(0, 15))
			0: cc = 0;
			1: lc = 0;
			2: cc = $urandom_range(129 - fc, 255);
			3: lc = $urandom_range(257 - fl, 511);
			4: np = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(5, 7);
			5: ns = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(17, 31);
			6: npg = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(65537, 131071);
			default: ;
		endcase
		return span_of(fc, cc, fl, lc, $urandom, np, npg, ns);
	endfunction

	task automatic queue_req(logic [KIND_W-1:0] k, logic [UNIT_W-1:0] u);
		flash_req_t r;
		r.k = k;
		r.u = u;
		pending_reqs.push_back(r);
		reqs_queued = reqs_queued + 1;
	endtask

	// Waits until every queued request was taken and every beat came back.
	// Every request yields at least one beat, so the block is idle then.
	task automatic settle();
		do
			@(negedge clk);
		while (reqs_accepted != reqs_queued || expected_addrs.size() != 0);
	endtask

	initial begin : stimulus
		int random_reqs, n, r, span_units;
		logic [KIND_W-1:0] k;
		logic [UNIT_W-1:0] u;
		random_reqs = 0;
		span = span_of(RST_FIRST_CHANNEL, RST_CHANNEL_COUNT, RST_FIRST_LUN, RST_LUN_COUNT,
			RST_BLOCK_NUMBER, RST_PLANE_COUNT, RST_PAGE_COUNT, RST_SECTOR_COUNT);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_mode = 1;
		rx_mode = 2;

		// Register defaults after reset: one channel, one die, one plane.
		// The second erase lies just outside the span; kind 3 is unused.
		queue_req(OP_ERASE, 32'd0);
		queue_req(OP_ERASE, 32'd1);
		queue_req(OP_WRITE, 32'd0);
		queue_req(OP_READ, 32'hFFFF_FFFF);
		queue_req(OP_UNUSED, 32'd5);
		settle();

		// Upper corner of every register but the channel and die counts: last channel and die, quad plane,
		// 64-beat runs and the full page range.
		load_span(span_of(127, 1, 255, 1, 65535, 4, 65536, 16));
		queue_req(OP_ERASE, 32'd0);
		queue_req(OP_ERASE, 32'd1);
		queue_req(OP_WRITE, 32'hFFFF_FFFF);
		queue_req(OP_READ, 32'h1234_5678);
		settle();

		// Widest span with dual planes and single-page blocks; the last pair
		// index and the one after it.
		tx_mode = 0;
		rx_mode = 0;
		load_span(span_of(0, 128, 0, 256, 16'h5A5A, 2, 1, 1));
		queue_req(OP_ERASE, 32'd0);
		queue_req(OP_ERASE, 32'd32767);
		queue_req(OP_ERASE, 32'd32768);
		queue_req(OP_WRITE, 32'hFFFF_FFFF);
		queue_req(OP_READ, 32'd129);
		queue_req(OP_UNUSED, 32'd0);
		settle();

		// Three planes report single plane mode.
		rx_mode = 1;
		load_span(span_of(10, 3, 20, 5, 1234, 3, 7, 3));
		queue_req(OP_ERASE, 32'd14);
		queue_req(OP_WRITE, 32'd1000);
		queue_req(OP_READ, 32'd77777);
		settle();

		// Channel range runs past the last channel.
		load_span(span_of(100, 29, 0, 1, 0, 1, 16, 1));
		queue_req(OP_ERASE, 32'd0);
		queue_req(OP_WRITE, 32'd5);
		settle();

		// Empty channel span.
		load_span(span_of(0, 0, 0, 1, 0, 1, 16, 1));
		queue_req(OP_READ, 32'd1);
		settle();

		// Random phases, each with a fresh span and its own idling style.
		while (random_reqs < RANDOM_REQS) begin
			load_span(random_span());
			tx_mode = $urandom_range(0, 1);
			rx_mode = $urandom_range(0, 2);
			span_units = int'(span.channel_count) * int'(span.lun_count);
			n = $urandom_range(8, 40);
			repeat (n) begin
				r = $urandom_range(0, 19);
				k = (r < 6) ? OP_ERASE : (r < 12) ? OP_WRITE : (r < 19) ? OP_READ : OP_UNUSED;
				if (k == OP_ERASE) begin
					// Mostly pairs inside the span, plus the first one beyond
					// it and arbitrary indexes.
					case ($urandom_range(0, 5))
						0: u = $urandom;
						1: u = span_units;
						default: u = (span_units > 0) ? $urandom_range(0, span_units - 1) : $urandom;
					endcase
				end else begin
					u = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 4095);
				end
				queue_req(k, u);
				random_reqs = random_reqs + 1;
			end
			settle();
		end

		// Give any stray beat time to show up before the verdict.
		repeat (60) @(posedge clk);
		if (mismatches == 0 && expected_addrs.size() == 0)
			$display("tb_spanning_block_address_generator OK");
		else
			$display("tb_spanning_block_address_generator NOT OK");
		$finish;
	end

endmodule
